// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

    // command codes carried in the mode field, also used as the engine's command kind
    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_SEND  = 3'd3,
        MODE_WAIT  = 3'd4,
        MODE_READ  = 3'd5
    } mode_t;

    // configuration register indexes
    localparam logic CFG_DELAY_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam int CFG_WIDTH = 16;

    localparam logic [CFG_WIDTH-1:0] DELAY_TICKS_RST = 16'd30;
    localparam logic [CFG_WIDTH-1:0] ACK_TIMEOUT_RST = 16'd250;

    // one input item: a single engine tick
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_line;
    } i2cm_in_t;

    // one result item: pin and status state after the tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } i2cm_out_t;

endpackage

// ===== rtl/i2cm_core.sv =====
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic                 cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic                 step_en,
    input  i2cm_in_t             in_item,
    output i2cm_out_t            out_item
);

    mode_t       kind_reg, kind_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  bit_reg, bit_next;
    logic [15:0] ptimer_reg, ptimer_next;
    logic [15:0] wtimer_reg, wtimer_next;
    logic [7:0]  shift_reg, shift_next;
    logic        ack_reg, ack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drv_reg, drv_next;
    logic        fail_reg, fail_next;
    logic [7:0]  rx_reg, rx_next;
    logic [15:0] delay_reg;
    logic [15:0] timeout_reg;

    logic [15:0] dl;
    logic [15:0] ptimer_inc;
    logic        done;

    assign dl         = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
    assign ptimer_inc = ptimer_reg + 16'd1;

    // next engine state for one tick
    always_comb begin
        kind_next   = kind_reg;
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        ptimer_next = ptimer_reg;
        wtimer_next = wtimer_reg;
        shift_next  = shift_reg;
        ack_next    = ack_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        drv_next    = drv_reg;
        fail_next   = fail_reg;
        rx_next     = rx_reg;
        done        = 1'b0;

        if (kind_reg == MODE_NONE) begin
            // idle: take a new command
            phase_next  = 2'd0;
            ptimer_next = 16'd0;
            bit_next    = 3'd0;
            unique case (in_item.mode)
                MODE_START: begin
                    drv_next  = 1'b1;
                    sda_next  = 1'b1;
                    scl_next  = 1'b1;
                    kind_next = MODE_START;
                end
                MODE_STOP: begin
                    drv_next  = 1'b1;
                    scl_next  = 1'b0;
                    sda_next  = 1'b0;
                    kind_next = MODE_STOP;
                end
                MODE_SEND: begin
                    drv_next   = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = in_item.tx_byte[7];
                    shift_next = {in_item.tx_byte[6:0], 1'b0};
                    kind_next  = MODE_SEND;
                end
                MODE_WAIT: begin
                    fail_next   = 1'b0;
                    wtimer_next = 16'd0;
                    drv_next    = 1'b0;
                    sda_next    = 1'b1;
                    kind_next   = MODE_WAIT;
                end
                MODE_READ: begin
                    drv_next   = 1'b0;
                    scl_next   = 1'b0;
                    shift_next = 8'd0;
                    ack_next   = in_item.send_ack;
                    kind_next  = MODE_READ;
                end
                default: begin
                end
            endcase
        end else if (kind_reg == MODE_WAIT && phase_reg == 2'd2) begin
            // acknowledge polling, one sample per tick
            if (!in_item.sda_line) begin
                scl_next    = 1'b0;
                kind_next   = MODE_NONE;
                phase_next  = 2'd0;
                ptimer_next = 16'd0;
                done        = 1'b1;
            end else if (wtimer_reg >= timeout_reg) begin
                fail_next   = 1'b1;
                kind_next   = MODE_STOP;
                phase_next  = 2'd0;
                ptimer_next = 16'd0;
                drv_next    = 1'b1;
                scl_next    = 1'b0;
                sda_next    = 1'b0;
            end else begin
                wtimer_next = wtimer_reg + 16'd1;
            end
        end else if (ptimer_inc < dl) begin
            ptimer_next = ptimer_inc;
        end else begin
            // phase boundary
            ptimer_next = 16'd0;
            unique case (kind_reg)
                MODE_START: begin
                    if (phase_reg == 2'd0) begin
                        sda_next   = 1'b0;
                        phase_next = 2'd1;
                    end else begin
                        scl_next   = 1'b0;
                        kind_next  = MODE_NONE;
                        phase_next = 2'd0;
                        done       = 1'b1;
                    end
                end
                MODE_STOP: begin
                    if (phase_reg == 2'd0) begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = 2'd1;
                    end else begin
                        kind_next  = MODE_NONE;
                        phase_next = 2'd0;
                        done       = 1'b1;
                    end
                end
                MODE_SEND: begin
                    if (phase_reg == 2'd0) begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end else if (phase_reg == 2'd1) begin
                        scl_next   = 1'b0;
                        phase_next = 2'd2;
                    end else if (bit_reg == 3'd7) begin
                        kind_next  = MODE_NONE;
                        phase_next = 2'd0;
                        done       = 1'b1;
                    end else begin
                        bit_next   = bit_reg + 3'd1;
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = 2'd0;
                    end
                end
                MODE_WAIT: begin
                    if (phase_reg == 2'd0) begin
                        scl_next   = 1'b1;
                        phase_next = 2'd1;
                    end else begin
                        wtimer_next = 16'd0;
                        phase_next  = 2'd2;
                    end
                end
                MODE_READ: begin
                    if (phase_reg == 2'd0) begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[6:0], in_item.sda_line};
                        phase_next = 2'd1;
                    end else if (phase_reg == 2'd1) begin
                        scl_next = 1'b0;
                        if (bit_reg != 3'd7) begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = 2'd0;
                        end else begin
                            rx_next    = shift_reg;
                            drv_next   = 1'b1;
                            sda_next   = !ack_reg;
                            phase_next = 2'd2;
                        end
                    end else if (phase_reg == 2'd2) begin
                        scl_next   = 1'b1;
                        phase_next = 2'd3;
                    end else begin
                        scl_next   = 1'b0;
                        kind_next  = MODE_NONE;
                        phase_next = 2'd0;
                        done       = 1'b1;
                    end
                end
                default: begin
                    kind_next  = MODE_NONE;
                    phase_next = 2'd0;
                    done       = 1'b1;
                end
            endcase
        end
    end

    // result of this tick
    always_comb begin
        out_item.scl_level  = scl_next;
        out_item.sda_level  = sda_next;
        out_item.sda_drive  = drv_next;
        out_item.busy_res   = (kind_next != MODE_NONE);
        out_item.done_res   = done;
        out_item.rx_byte    = rx_next;
        out_item.ack_failed = fail_next;
    end

    // engine state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= MODE_NONE;
            phase_reg   <= 2'd0;
            bit_reg     <= 3'd0;
            ptimer_reg  <= 16'd0;
            wtimer_reg  <= 16'd0;
            shift_reg   <= 8'd0;
            ack_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drv_reg     <= 1'b1;
            fail_reg    <= 1'b0;
            rx_reg      <= 8'd0;
            delay_reg   <= DELAY_TICKS_RST;
            timeout_reg <= ACK_TIMEOUT_RST;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == CFG_DELAY_TICKS) begin
                    delay_reg <= cfg_wdata;
                end else begin
                    timeout_reg <= cfg_wdata;
                end
            end
            if (step_en) begin
                kind_reg   <= kind_next;
                phase_reg  <= phase_next;
                bit_reg    <= bit_next;
                ptimer_reg <= ptimer_next;
                wtimer_reg <= wtimer_next;
                shift_reg  <= shift_next;
                ack_reg    <= ack_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                drv_reg    <= drv_next;
                fail_reg   <= fail_next;
                rx_reg     <= rx_next;
            end
        end
    end

    // start and stop run through two phases only
    a_short_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == MODE_START || kind_reg == MODE_STOP) |-> phase_reg <= 2'd1)
        else $error("start or stop beyond its last phase");

    // idle engine holds no phase progress
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == MODE_NONE |-> (phase_reg == 2'd0 && ptimer_reg == 16'd0))
        else $error("idle engine with stale phase");

    // a finished command always leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && done) |=> kind_reg == MODE_NONE)
        else $error("command finished but engine not idle");

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine, one input item per engine tick.
// The input channel (s_valid/s_ready/s_data) carries a tick: an optional
// command (start, stop, send byte, wait ack, read byte) and the sampled
// SDA level. Commands arriving while a command is busy are ignored.
// The result channel (m_valid/m_ready/m_data) returns one item per input
// item: SCL level, SDA level and direction, busy, done pulse, last read
// byte and the ack failure flag, all as they stand after that tick.
// Each result is registered in the output register, or in the skid slot.
// Throughput: one item per cycle while s_ready is high.
// A two-slot output buffer lets the block take one more item while a
// result waits; with both slots full s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) idles the engine with SCL and SDA high
// and driven, clears the flags and the read byte, and loads delay_ticks
// 30 and ack_timeout 250. The cfg port writes delay_ticks (index 0) and
// ack_timeout (index 1); write them only while idle.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic                 cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cm_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cm_out_t            m_data
);

    i2cm_out_t result;
    i2cm_out_t m_data_reg;
    i2cm_out_t skid_data_reg;
    logic      m_valid_reg;
    logic      skid_valid_reg;
    logic      in_fire;
    logic      out_fire;

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    i2cm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_en   (in_fire),
        .in_item   (s_data),
        .out_item  (result)
    );

    // output register with a skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= in_fire;
            if (in_fire) begin
                m_data_reg <= result;
            end
        end else if (in_fire) begin
            skid_data_reg  <= result;
            skid_valid_reg <= 1'b1;
        end
    end

    // the skid slot is only used behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid slot full with empty output register");

    // an item taken while the output stalls lands in the skid slot
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("stalled item not captured");

    // output drains when taken with nothing behind it
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !skid_valid_reg && !in_fire) |=> !m_valid_reg)
        else $error("result repeated");

    // a done pulse never comes with busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.done_res) |-> !m_data_reg.busy_res)
        else $error("done raised while busy");

endmodule
